// File: hw/rtl/rsfr_pkg.sv
// rsfr_pkg: shared types, constants and the crc helper of the frame receiver
// used by rsfr_ctrl, rsfr_datapath and rs485_frame_receiver; no dependencies
package rsfr_pkg;

  // default frame store depth and cap on replayed payload items
  localparam int FRAME_BYTES_DEF = 64;
  localparam int MAX_RESULTS     = 64;

  // sync pattern
  localparam logic [7:0] SYNC_FIRST  = 8'h08;
  localparam logic [7:0] SYNC_SECOND = 8'h70;

  // modbus crc-16, reflected form
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // configuration registers
  localparam int          CFG_ADDR_W      = 2;
  localparam int          CFG_DATA_W      = 16;
  localparam logic [1:0]  REG_OWN_NODE    = 2'd0;
  localparam logic [1:0]  REG_CMD_THRESH  = 2'd1;
  localparam logic [1:0]  REG_TIMEOUT     = 2'd2;
  localparam logic [15:0] TIMEOUT_RST     = 16'd1000;

  // status codes of a result item
  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_CRC_ERR   = 2'd1,
    STS_OTHER     = 2'd2,
    STS_DROP      = 2'd3
  } status_t;

  // receiver phases, including the two replay steps
  typedef enum logic [2:0] {
    PH_HUNT,
    PH_SYNC2,
    PH_LEN,
    PH_DATA,
    PH_CRC_LO,
    PH_CRC_HI,
    PH_READ,
    PH_EMIT
  } phase_t;

  // commands from controller to datapath
  typedef struct packed {
    logic    hunt_clr;
    logic    len_load;
    logic    data_take;
    logic    crc_lo_take;
    logic    tick_inc;
    logic    emit_status;
    status_t emit_code;
    logic    busy_other;
    logic    busy_clear;
    logic    rd_start;
    logic    rd_issue;
    logic    emit_data;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic is_tick;
    logic is_sync1;
    logic is_sync2;
    logic len_over;
    logic byte_zero;
    logic len_zero;
    logic data_done;
    logic timeout_hit;
    logic crc_ok;
    logic node_match;
    logic rd_last;
    logic out_free;
  } stat_t;

  // one byte through the reflected crc, eight shift steps
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: hw/rtl/rs485_frame_receiver.sv
// rs485_frame_receiver: sync/length/payload deframer with modbus crc-16 check
// each status item is registered in the result register when its byte or tick is accepted; an
// accepted frame is replayed through PH_READ (registered frame store read) and PH_EMIT per payload byte
// throughput: one byte or tick per cycle while no replay runs and the result slot is free
// reset: synchronous active-low rst_n; hunting for sync, bus ready, timeout 1000 ticks
// depends on rsfr_pkg, rsfr_ctrl and rsfr_datapath
module rs485_frame_receiver #(
  parameter int FRAME_BYTES = rsfr_pkg::FRAME_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [rsfr_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [rsfr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [7:0] rx_byte
  input  logic [0:0]                      in_tuser,   // [0] req_type
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [15:0]                     out_tdata,  // [7:0] data_byte, [13:8] byte_index,
                                                      // [14] busy flag, [15] zero
  output logic [2:0]                      out_tuser,  // [1:0] status, [2] has_data
  output logic                            out_tlast
);

  rsfr_pkg::cmd_t    cmd;
  rsfr_pkg::stat_t   stat;
  rsfr_pkg::status_t out_status;
  logic              out_has_data;
  logic [7:0]        out_data_byte;
  logic [5:0]        out_byte_index;
  logic              out_line_busy;

  // phase controller
  rsfr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath with frame store and result register
  rsfr_datapath #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .in_req_type    (in_tuser[0]),
    .in_byte        (in_tdata),
    .cmd            (cmd),
    .stat           (stat),
    .out_tready     (out_tready),
    .out_valid      (out_tvalid),
    .out_status     (out_status),
    .out_has_data   (out_has_data),
    .out_data_byte  (out_data_byte),
    .out_byte_index (out_byte_index),
    .out_line_busy  (out_line_busy),
    .out_last       (out_tlast)
  );

  // result packing
  assign out_tdata = {1'b0, out_line_busy, out_byte_index, out_data_byte};
  assign out_tuser = {out_has_data, out_status};

endmodule

// File: hw/rtl/rsfr_ctrl.sv
// rsfr_ctrl: phase state machine of the frame receiver
// depends on rsfr_pkg; drives rsfr_datapath through cmd_t, watches stat_t
module rsfr_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  rsfr_pkg::stat_t stat,
  output rsfr_pkg::cmd_t  cmd
);

  rsfr_pkg::phase_t phase_r, phase_nxt;
  logic in_fire;
  logic take_tick;
  logic take_byte;

  assign in_tready = stat.out_free &&
                     (phase_r != rsfr_pkg::PH_READ) && (phase_r != rsfr_pkg::PH_EMIT);
  assign in_fire   = in_tvalid && in_tready;
  assign take_tick = in_fire && stat.is_tick;
  assign take_byte = in_fire && !stat.is_tick;

  // phase register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= rsfr_pkg::PH_HUNT;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      rsfr_pkg::PH_HUNT: begin
        if (take_byte && stat.is_sync1) phase_nxt = rsfr_pkg::PH_SYNC2;
      end
      rsfr_pkg::PH_SYNC2: begin
        if (take_byte) phase_nxt = stat.is_sync2 ? rsfr_pkg::PH_LEN : rsfr_pkg::PH_HUNT;
      end
      rsfr_pkg::PH_LEN: begin
        if (take_byte) begin
          if (stat.len_over)       phase_nxt = rsfr_pkg::PH_HUNT;
          else if (stat.byte_zero) phase_nxt = rsfr_pkg::PH_CRC_LO;
          else                     phase_nxt = rsfr_pkg::PH_DATA;
        end
      end
      rsfr_pkg::PH_DATA: begin
        if (take_tick && stat.timeout_hit)    phase_nxt = rsfr_pkg::PH_HUNT;
        else if (take_byte && stat.data_done) phase_nxt = rsfr_pkg::PH_CRC_LO;
      end
      rsfr_pkg::PH_CRC_LO: begin
        if (take_tick && stat.timeout_hit) phase_nxt = rsfr_pkg::PH_HUNT;
        else if (take_byte)                phase_nxt = rsfr_pkg::PH_CRC_HI;
      end
      rsfr_pkg::PH_CRC_HI: begin
        if (take_tick && stat.timeout_hit) begin
          phase_nxt = rsfr_pkg::PH_HUNT;
        end else if (take_byte) begin
          if (stat.crc_ok && stat.node_match && !stat.len_zero) phase_nxt = rsfr_pkg::PH_READ;
          else                                                  phase_nxt = rsfr_pkg::PH_HUNT;
        end
      end
      rsfr_pkg::PH_READ: begin
        phase_nxt = rsfr_pkg::PH_EMIT;
      end
      rsfr_pkg::PH_EMIT: begin
        if (stat.out_free) phase_nxt = stat.rd_last ? rsfr_pkg::PH_HUNT : rsfr_pkg::PH_READ;
      end
      default: phase_nxt = rsfr_pkg::PH_HUNT;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd = '0;
    case (phase_r)
      rsfr_pkg::PH_HUNT, rsfr_pkg::PH_SYNC2: begin
      end
      rsfr_pkg::PH_LEN: begin
        if (take_byte) begin
          if (stat.len_over) begin
            cmd.hunt_clr    = 1'b1;
            cmd.emit_status = 1'b1;
            cmd.emit_code   = rsfr_pkg::STS_DROP;
          end else begin
            cmd.len_load = 1'b1;
          end
        end
      end
      rsfr_pkg::PH_DATA, rsfr_pkg::PH_CRC_LO, rsfr_pkg::PH_CRC_HI: begin
        // ticks while a frame is open
        if (take_tick) begin
          if (stat.timeout_hit) begin
            cmd.hunt_clr    = 1'b1;
            cmd.emit_status = 1'b1;
            cmd.emit_code   = rsfr_pkg::STS_DROP;
          end else begin
            cmd.tick_inc = 1'b1;
          end
        end
        if (take_byte) begin
          if (phase_r == rsfr_pkg::PH_DATA) begin
            cmd.data_take = 1'b1;
          end else if (phase_r == rsfr_pkg::PH_CRC_LO) begin
            cmd.crc_lo_take = 1'b1;
          end else begin
            // frame complete: check crc, then address
            cmd.hunt_clr = 1'b1;
            if (!stat.crc_ok) begin
              cmd.emit_status = 1'b1;
              cmd.emit_code   = rsfr_pkg::STS_CRC_ERR;
            end else if (!stat.node_match) begin
              cmd.busy_other  = 1'b1;
              cmd.emit_status = 1'b1;
              cmd.emit_code   = rsfr_pkg::STS_OTHER;
            end else begin
              cmd.busy_clear = 1'b1;
              if (stat.len_zero) begin
                cmd.emit_status = 1'b1;
                cmd.emit_code   = rsfr_pkg::STS_OK;
              end else begin
                cmd.rd_start = 1'b1;
              end
            end
          end
        end
      end
      rsfr_pkg::PH_READ: begin
        cmd.rd_issue = 1'b1;
      end
      rsfr_pkg::PH_EMIT: begin
        cmd.emit_data = stat.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// File: hw/rtl/rsfr_datapath.sv
// rsfr_datapath: config registers, counters, crc, frame store and result register
// depends on rsfr_pkg; commanded by rsfr_ctrl
module rsfr_datapath #(
  parameter int FRAME_BYTES = rsfr_pkg::FRAME_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [rsfr_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [rsfr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_req_type,
  input  logic [7:0]                        in_byte,
  input  rsfr_pkg::cmd_t                    cmd,
  output rsfr_pkg::stat_t                   stat,
  input  logic                              out_tready,
  output logic                              out_valid,
  output rsfr_pkg::status_t                 out_status,
  output logic                              out_has_data,
  output logic [7:0]                        out_data_byte,
  output logic [5:0]                        out_byte_index,
  output logic                              out_line_busy,
  output logic                              out_last
);

  localparam int         ADDR_W  = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam logic [7:0] LEN_MAX = 8'(FRAME_BYTES);
  localparam logic [7:0] RES_MAX = 8'(rsfr_pkg::MAX_RESULTS);

  // configuration
  logic [7:0]  own_node_r;
  logic [7:0]  cmd_thresh_r;
  logic [15:0] timeout_r;

  // frame state
  logic [7:0]  len_r;
  logic [7:0]  taken_r;
  logic [15:0] crc_r;
  logic [7:0]  crc_lo_r;
  logic [15:0] tick_r;
  logic [7:0]  dest_r;
  logic [7:0]  code_r;
  logic        busy_r;
  logic        busy_nxt;
  logic [7:0]  rd_cnt_r;
  logic [7:0]  rd_data_r;
  logic [7:0]  replay_n;
  logic [15:0] tick_nxt;

  // result register
  logic              out_valid_r;
  rsfr_pkg::status_t out_status_r;
  logic              out_has_r;
  logic [7:0]        out_data_r;
  logic [5:0]        out_idx_r;
  logic              out_busy_r;
  logic              out_last_r;

  logic [7:0] mem [FRAME_BYTES];

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_node_r   <= 8'd0;
      cmd_thresh_r <= 8'd0;
      timeout_r    <= rsfr_pkg::TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        rsfr_pkg::REG_OWN_NODE:   own_node_r   <= cfg_wdata[7:0];
        rsfr_pkg::REG_CMD_THRESH: cmd_thresh_r <= cfg_wdata[7:0];
        rsfr_pkg::REG_TIMEOUT:    timeout_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // saturating tick count
  assign tick_nxt = (tick_r == 16'hFFFF) ? tick_r : tick_r + 16'd1;

  // frame counters, crc and the destination and code bytes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r    <= 8'd0;
      taken_r  <= 8'd0;
      crc_r    <= rsfr_pkg::CRC_INIT;
      crc_lo_r <= 8'd0;
      tick_r   <= 16'd0;
      dest_r   <= 8'd0;
      code_r   <= 8'd0;
      busy_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      if (cmd.hunt_clr) begin
        taken_r  <= 8'd0;
        crc_r    <= rsfr_pkg::CRC_INIT;
        crc_lo_r <= 8'd0;
        tick_r   <= 16'd0;
      end else begin
        if (cmd.len_load) begin
          len_r   <= in_byte;
          taken_r <= 8'd0;
          crc_r   <= rsfr_pkg::CRC_INIT;
          tick_r  <= 16'd0;
          dest_r  <= 8'd0;
          code_r  <= 8'd0;
        end
        if (cmd.data_take) begin
          crc_r   <= rsfr_pkg::crc_byte(crc_r, in_byte);
          taken_r <= taken_r + 8'd1;
          if (taken_r == 8'd1) dest_r <= in_byte;
          if (taken_r == 8'd3) code_r <= in_byte;
        end
        if (cmd.crc_lo_take) crc_lo_r <= in_byte;
        if (cmd.tick_inc)    tick_r   <= tick_nxt;
      end
    end
  end

  // busy flag after this frame
  always_comb begin
    busy_nxt = busy_r;
    if (cmd.busy_other)      busy_nxt = (code_r > cmd_thresh_r);
    else if (cmd.busy_clear) busy_nxt = 1'b0;
  end

  // frame store: write while receiving, registered read during replay
  always_ff @(posedge clk) begin
    if (cmd.data_take) mem[taken_r[ADDR_W-1:0]] <= in_byte;
    if (cmd.rd_issue)  rd_data_r <= mem[rd_cnt_r[ADDR_W-1:0]];
  end

  // replay position
  assign replay_n = (len_r > RES_MAX) ? RES_MAX : len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_cnt_r <= 8'd0;
    end else if (cmd.rd_start) begin
      rd_cnt_r <= 8'd0;
    end else if (cmd.emit_data) begin
      rd_cnt_r <= rd_cnt_r + 8'd1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_status || cmd.emit_data) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_status) begin
      out_status_r <= cmd.emit_code;
      out_has_r    <= 1'b0;
      out_data_r   <= 8'd0;
      out_idx_r    <= 6'd0;
      out_busy_r   <= busy_nxt;
      out_last_r   <= 1'b1;
    end else if (cmd.emit_data) begin
      out_status_r <= rsfr_pkg::STS_OK;
      out_has_r    <= 1'b1;
      out_data_r   <= rd_data_r;
      out_idx_r    <= rd_cnt_r[5:0];
      out_busy_r   <= busy_r;
      out_last_r   <= stat.rd_last;
    end
  end

  // status toward the controller
  always_comb begin
    stat.is_tick     = in_req_type;
    stat.is_sync1    = (in_byte == rsfr_pkg::SYNC_FIRST);
    stat.is_sync2    = (in_byte == rsfr_pkg::SYNC_SECOND);
    stat.len_over    = (in_byte > LEN_MAX);
    stat.byte_zero   = (in_byte == 8'd0);
    stat.len_zero    = (len_r == 8'd0);
    stat.data_done   = ({1'b0, taken_r} + 9'd1) >= {1'b0, len_r};
    stat.timeout_hit = (tick_nxt > timeout_r);
    stat.crc_ok      = ({in_byte, crc_lo_r} == crc_r);
    stat.node_match  = (dest_r == own_node_r);
    stat.rd_last     = ((rd_cnt_r + 8'd1) == replay_n);
    stat.out_free    = !out_valid_r || out_tready;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_has_data   = out_has_r;
  assign out_data_byte  = out_data_r;
  assign out_byte_index = out_idx_r;
  assign out_line_busy  = out_busy_r;
  assign out_last       = out_last_r;

endmodule
